@@ design/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared codes and types for the bitmap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  localparam logic [2:0] FUNC_ALLOC = 3'd0;
  localparam logic [2:0] FUNC_FREE  = 3'd1;
  localparam logic [2:0] FUNC_MARK  = 3'd2;
  localparam logic [2:0] FUNC_CHECK = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAME  = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_GROW  = 3'd1;
  localparam logic [2:0] KIND_FREE  = 3'd2;
  localparam logic [2:0] KIND_MARK  = 3'd3;
  localparam logic [2:0] KIND_CHECK = 3'd4;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffs_t;

endpackage

`default_nettype wire

@@ design/bsa_ffs.sv @@
// ----------------------------------------------------------------------------
// bsa_ffs
// Find-first-set over one bitmap word, split into eight groups of eight.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ffs (
  input  logic [63:0]   vec_i,
  output bsa_pkg::ffs_t res_o
);
  import bsa_pkg::*;

  localparam int unsigned GRP = 8;

  logic [GRP-1:0] grp_any;
  logic [2:0]     grp_sel;
  logic [2:0]     bit_sel;
  logic [GRP-1:0] grp_bits;

  always_comb begin
    for (int g = 0; g < GRP; g++) begin
      grp_any[g] = |vec_i[g*GRP +: GRP];
    end
    grp_sel = '0;
    for (int g = GRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = 3'(g);
      end
    end
    grp_bits = vec_i[{grp_sel, 3'b000} +: GRP];
    bit_sel = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = 3'(b);
      end
    end
    res_o.found = |grp_any;
    res_o.pos   = {grp_sel, bit_sel};
  end

endmodule

`default_nettype wire

@@ design/bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Next-fit slot allocator over a used bitmap held in a 64-bit word memory.
// ----------------------------------------------------------------------------
// Free, mark, check: ST_RD, ST_MOD, ST_DONE (only ST_DONE when out of range).
// Allocate: one bitmap word read per cycle from the hint, two passes at most;
//   then ST_ENC, ST_RD, ST_MOD, ST_DONE; a miss on both passes goes to ST_GROW.
// Clear: zeroing sweep, one word per cycle, then ST_DONE.
// One item at a time; next beat taken once the result sits in the output reg.
// After reset a clearing pass over every bitmap word runs with in_stall_o high.
`default_nettype none

module bitmap_slot_allocator #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [9:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [9:0]  granted_o,
  output logic        in_use_o,
  output logic [10:0] table_size_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsa_pkg::*;

  localparam int unsigned SZ_W     = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned NWORDS   = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned WC_W     = WA_W + 1;
  localparam int unsigned RST_SIZE = (CAPACITY < 64) ? CAPACITY : 64;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_ENC  = 3'd3;
  localparam logic [2:0] ST_GROW = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_MOD  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // control state
  logic [2:0]      state_q, state_d;
  logic [SZ_W-1:0] size_q, size_d;
  logic [SZ_W-1:0] grow_q, grow_d;
  logic [SZ_W-1:0] hint_q, hint_d;
  logic [10:0]     init_cfg_q, max_cfg_q;
  logic [WA_W-1:0] clr_q, clr_d;
  logic            clr_op_q, clr_op_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_valid_q, out_valid_d;

  // datapath
  logic            pass_q, pass_d;
  logic [SZ_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [WC_W-1:0] iss_q, iss_d, last_q, last_d;
  logic [WA_W-1:0] rd_word_q, rd_word_d;
  logic [63:0]     free_q, free_d;
  logic [WA_W-1:0] fword_q, fword_d;
  logic [IDX_W-1:0] target_q, target_d;
  logic [2:0]      kind_q, kind_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [9:0]      res_granted_q, res_granted_d;
  logic            res_in_use_q, res_in_use_d;
  logic [1:0]      out_status_q;
  logic [9:0]      out_granted_q;
  logic            out_in_use_q;
  logic [10:0]     out_size_q;

  // bitmap memory
  logic [63:0]     mem_q [NWORDS];
  logic [63:0]     rdata_q;
  logic            mem_we, mem_re;
  logic [WA_W-1:0] mem_waddr, mem_raddr;
  logic [63:0]     mem_wdata;

  logic [SZ_W-1:0] eff_init, eff_max;
  logic [SZ_W:0]   grow_sum, grow_dbl;
  logic [SZ_W-1:0] grow_size, grow_next;
  logic [WA_W-1:0] t_word;
  logic [5:0]      t_bit;
  logic [63:0]     t_onehot;
  logic            t_cur;
  logic [63:0]     lomask, himask, free_v;
  logic            hit;
  logic            slot_in_range;
  logic            start_scan;
  logic [SZ_W-1:0] start_lo, start_hi;
  logic            single_op;
  logic            out_load;
  logic            cfg_wr;
  ffs_t            ffs;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cfg_q <= 11'd64;
      max_cfg_q  <= 11'd1024;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        max_cfg_q <= pwdata[10:0];
      end else begin
        init_cfg_q <= pwdata[10:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(max_cfg_q) : 32'(init_cfg_q);

  // ---- effective sizes and growth ----
  always_comb begin
    if (init_cfg_q == '0) begin
      eff_init = SZ_W'(1);
    end else if (32'(init_cfg_q) > 32'(CAPACITY)) begin
      eff_init = SZ_W'(CAPACITY);
    end else begin
      eff_init = SZ_W'(init_cfg_q);
    end
    if (max_cfg_q == '0 || 32'(max_cfg_q) > 32'(CAPACITY)) begin
      eff_max = SZ_W'(CAPACITY);
    end else begin
      eff_max = SZ_W'(max_cfg_q);
    end
    grow_sum  = {1'b0, size_q} + {1'b0, grow_q};
    grow_size = (grow_sum > {1'b0, eff_max}) ? eff_max : SZ_W'(grow_sum);
    grow_dbl  = {grow_q, 1'b0};
    grow_next = (grow_dbl > (SZ_W + 1)'(CAPACITY)) ? SZ_W'(CAPACITY) : SZ_W'(grow_dbl);
  end

  // ---- target slot decode ----
  assign t_word   = WA_W'(32'(target_q) >> BIT_W);
  assign t_bit    = 6'(32'(target_q));
  assign t_onehot = 64'(1) << t_bit;
  assign t_cur    = rdata_q[t_bit];

  assign slot_in_range = 32'(slot_i) < 32'(size_q);

  // ---- scan window of the returning word ----
  always_comb begin
    if (32'(rd_word_q) == (32'(lo_q) >> BIT_W)) begin
      lomask = {64{1'b1}} << 6'(32'(lo_q));
    end else begin
      lomask = '1;
    end
    if (32'(rd_word_q) == (32'(hi_q) >> BIT_W)) begin
      himask = ~({64{1'b1}} << 6'(32'(hi_q)));
    end else begin
      himask = '1;
    end
    free_v = ~rdata_q & lomask & himask;
    hit    = rd_vld_q & (|free_v);
  end

  bsa_ffs u_ffs (
    .vec_i (free_q),
    .res_o (ffs)
  );

  // ---- sequencer ----
  always_comb begin
    state_d       = state_q;
    size_d        = size_q;
    grow_d        = grow_q;
    hint_d        = hint_q;
    clr_d         = clr_q;
    clr_op_d      = clr_op_q;
    rd_vld_d      = rd_vld_q;
    pass_d        = pass_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    iss_d         = iss_q;
    last_d        = last_q;
    rd_word_d     = rd_word_q;
    free_d        = free_q;
    fword_d       = fword_q;
    target_d      = target_q;
    kind_d        = kind_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    res_in_use_d  = res_in_use_q;
    mem_we        = 1'b0;
    mem_waddr     = t_word;
    mem_wdata     = rdata_q;
    mem_re        = 1'b0;
    mem_raddr     = t_word;
    start_scan    = 1'b0;
    start_lo      = hint_q;
    start_hi      = size_q;
    single_op     = 1'b0;
    out_load      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_granted_d = slot_i;
          res_status_d  = STAT_OK;
          res_in_use_d  = 1'b0;
          case (func_i)
            FUNC_ALLOC: begin
              kind_d     = KIND_ALLOC;
              start_scan = 1'b1;
              if (hint_q < size_q) begin
                pass_d   = 1'b0;
                start_lo = hint_q;
                start_hi = size_q;
              end else begin
                pass_d   = 1'b1;
                start_lo = '0;
                start_hi = hint_q;
              end
            end
            FUNC_CLEAR: begin
              hint_d   = '0;
              size_d   = eff_init;
              grow_d   = eff_init;
              clr_d    = '0;
              clr_op_d = 1'b1;
              state_d  = ST_CLR;
            end
            FUNC_FREE: begin
              kind_d    = KIND_FREE;
              single_op = 1'b1;
            end
            FUNC_MARK: begin
              kind_d    = KIND_MARK;
              single_op = 1'b1;
            end
            default: begin
              kind_d    = KIND_CHECK;
              single_op = 1'b1;
            end
          endcase
          if (single_op) begin
            target_d = IDX_W'(32'(slot_i));
            if (slot_in_range) begin
              state_d = ST_RD;
            end else begin
              res_status_d = STAT_RANGE;
              state_d      = ST_DONE;
            end
          end
        end
      end

      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (32'(clr_q) == NWORDS - 1) begin
          state_d = clr_op_q ? ST_DONE : ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          free_d   = free_v;
          fword_d  = rd_word_q;
          rd_vld_d = 1'b0;
          state_d  = ST_ENC;
        end else if (iss_q <= last_q) begin
          mem_re    = 1'b1;
          mem_raddr = iss_q[WA_W-1:0];
          rd_vld_d  = 1'b1;
          rd_word_d = iss_q[WA_W-1:0];
          iss_d     = iss_q + 1'b1;
        end else begin
          rd_vld_d = 1'b0;
          if (!pass_q && hint_q != '0) begin
            pass_d     = 1'b1;
            start_scan = 1'b1;
            start_lo   = '0;
            start_hi   = hint_q;
          end else begin
            state_d = ST_GROW;
          end
        end
      end

      ST_ENC: begin
        target_d = IDX_W'((32'(fword_q) << BIT_W) | 32'(ffs.pos));
        state_d  = ST_RD;
      end

      ST_GROW: begin
        if (size_q >= eff_max) begin
          res_status_d  = STAT_FULL;
          res_granted_d = '0;
          state_d       = ST_DONE;
        end else begin
          kind_d   = KIND_GROW;
          target_d = IDX_W'(size_q);
          state_d  = ST_RD;
        end
      end

      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_MOD;
      end

      ST_MOD: begin
        state_d = ST_DONE;
        case (kind_q)
          KIND_ALLOC, KIND_GROW: begin
            mem_we        = 1'b1;
            mem_wdata     = rdata_q | t_onehot;
            hint_d        = SZ_W'(32'(target_q) + 32'd1);
            res_granted_d = 10'(32'(target_q));
            res_in_use_d  = 1'b1;
            if (kind_q == KIND_GROW) begin
              size_d = grow_size;
              grow_d = grow_next;
            end
          end
          KIND_FREE: begin
            if (t_cur) begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q & ~t_onehot;
              hint_d    = SZ_W'(target_q);
            end else begin
              res_status_d = STAT_SAME;
            end
          end
          KIND_MARK: begin
            res_in_use_d = 1'b1;
            if (t_cur) begin
              res_status_d = STAT_SAME;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q | t_onehot;
            end
          end
          default: begin
            res_in_use_d = t_cur;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_scan) begin
      lo_d     = start_lo;
      hi_d     = start_hi;
      iss_d    = WC_W'(32'(start_lo) >> BIT_W);
      last_d   = WC_W'((32'(start_hi) - 32'd1) >> BIT_W);
      rd_vld_d = 1'b0;
      state_d  = ST_SCAN;
    end
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      size_q      <= SZ_W'(RST_SIZE);
      grow_q      <= SZ_W'(RST_SIZE);
      hint_q      <= '0;
      clr_q       <= '0;
      clr_op_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      grow_q      <= grow_d;
      hint_q      <= hint_d;
      clr_q       <= clr_d;
      clr_op_q    <= clr_op_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pass_q        <= pass_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    iss_q         <= iss_d;
    last_q        <= last_d;
    rd_word_q     <= rd_word_d;
    free_q        <= free_d;
    fword_q       <= fword_d;
    target_q      <= target_d;
    kind_q        <= kind_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    res_in_use_q  <= res_in_use_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_granted_q <= res_granted_q;
      out_in_use_q  <= res_in_use_q;
      out_size_q    <= 11'(size_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign granted_o    = out_granted_q;
  assign in_use_o     = out_in_use_q;
  assign table_size_o = out_size_q;

  // ---- assertions ----
  a_hint_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hint_q <= size_q)
    else $error("hint beyond table size");

  a_size_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q != '0 && size_q <= SZ_W'(CAPACITY) && grow_q != '0 && grow_q <= SZ_W'(CAPACITY))
    else $error("table size or grow step out of range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat taken while busy");

  a_enc_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ENC) |-> ffs.found)
    else $error("encode without a free bit");

  a_grant_was_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD && (kind_q == KIND_ALLOC || kind_q == KIND_GROW)) |-> !t_cur)
    else $error("granted slot already in use");

endmodule

`default_nettype wire
